/* sv/rtoeb_pkg.sv */
// Shared types and constants for the TCP retransmission-timeout estimator.
package rtoeb_pkg;

   // Action codes carried in the input beat
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_EXPIRE = 2'd1;
   localparam logic [1:0] ACT_ARM    = 2'd2;

   // Configuration register indexes (byte address = 4 * index)
   localparam logic [1:0] CSR_INITIAL_RTO = 2'd0;
   localparam logic [1:0] CSR_MIN_RTO     = 2'd1;
   localparam logic [1:0] CSR_MAX_RTO     = 2'd2;

   localparam logic [31:0] INITIAL_RTO_RESET = 32'd1000000;
   localparam logic [31:0] MIN_RTO_RESET     = 32'd1000000;
   localparam logic [31:0] MAX_RTO_RESET     = 32'd240000000;

   localparam logic [3:0] RETRY_SAT = 4'd15;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_EXPIRE,
      OP_ARM,
      OP_IDLE
   } op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] send_time;
      logic [31:0] ack_time;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] rto;
      logic [31:0] smoothed_rtt;
      logic [31:0] rtt_variance;
      logic [31:0] lowest_rtt;
      logic [3:0]  retry_count;
      logic        abort_flag;
      logic [31:0] timeout_total;
   } rsp_payload_type;

   // Classified work item handed from front to back
   typedef struct packed {
      op_type      op;
      logic [31:0] rtt;
   } queue_item_type;

   typedef struct packed {
      logic [31:0] min_rto;
      logic [31:0] max_rto;
   } rto_limits_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
   } rto_load_type;

endpackage

/* sv/rtoeb_front.sv */
// Front stage: accepts input beats, forms the RTT sample and classifies the action.
module rtoeb_front
   import rtoeb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            push_valid,
   output queue_item_type  push_item,
   input  logic            queue_full
);

   logic           valid_ff;
   logic           valid_in;
   queue_item_type item_ff;
   queue_item_type item_in;
   logic           load;
   op_type         op_dec;

   always_comb begin
      unique case (req_payload.action)
         ACT_SAMPLE: op_dec = OP_SAMPLE;
         ACT_EXPIRE: op_dec = OP_EXPIRE;
         ACT_ARM:    op_dec = OP_ARM;
         default:    op_dec = OP_IDLE;
      endcase
   end

   // Hold the beat while the queue is full
   assign req_stall = valid_ff & queue_full;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      item_in.op  = op_dec;
      item_in.rtt = req_payload.ack_time - req_payload.send_time;
      valid_in    = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !queue_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

/* sv/rtoeb_queue.sv */
// Short queue between the front and back stages.
module rtoeb_queue
   import rtoeb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  queue_item_type push_item,
   output logic           full,
   output logic           pop_valid,
   output queue_item_type pop_item,
   input  logic           pop_ready
);

   localparam int PtrBits   = $clog2(QUEUE_DEPTH);
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   queue_item_type             entry_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]         wr_ptr_ff;
   logic [PtrBits-1:0]         wr_ptr_in;
   logic [PtrBits-1:0]         rd_ptr_ff;
   logic [PtrBits-1:0]         rd_ptr_in;
   logic [CountBits-1:0]       count_ff;
   logic [CountBits-1:0]       count_in;
   logic                       push;
   logic                       pop;

   assign full      = (count_ff == CountBits'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign push      = push_valid & ~full;
   assign pop       = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CountBits'(push) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/rtoeb_back.sv */
// Back stage: estimator state, backoff logic and the result register.
module rtoeb_back
   import rtoeb_pkg::*;
#(
   parameter int MAX_RETRIES = 12
)
(
   input  logic            clock,
   input  logic            reset,
   input  rto_limits_type  limits,
   input  rto_load_type    init_load,
   input  logic            item_valid,
   input  queue_item_type  item,
   output logic            item_ready,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [3:0] RetryLimit = 4'(MAX_RETRIES);

   logic [31:0]     srtt_ff, srtt_in;
   logic [31:0]     rttvar_ff, rttvar_in;
   logic [31:0]     rto_ff, rto_in;
   logic            measured_ff, measured_in;
   logic [31:0]     min_rtt_ff, min_rtt_in;
   logic [3:0]      retry_ff, retry_in;
   logic [31:0]     timeout_ff, timeout_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type payload_ff, payload_in;

   logic            take;
   logic            abort_now;
   logic [31:0]     rtt;
   logic [31:0]     diff;
   logic [33:0]     var_sum;
   logic [34:0]     srtt_sum;
   logic [31:0]     srtt_smp;
   logic [31:0]     var_smp;
   logic [33:0]     var_term;
   logic [33:0]     var_floor;
   logic [34:0]     rto_sum;
   logic [31:0]     rto_smp;
   logic [32:0]     rto_dbl;
   logic [31:0]     rto_exp;
   logic [3:0]      retry_inc;

   // Advance whenever the result register is free or being drained
   assign item_ready = ~rsp_valid_ff | ~rsp_stall;
   assign take       = item_valid & item_ready;
   assign rtt        = item.rtt;

   // Sample datapath
   always_comb begin
      diff     = (srtt_ff >= rtt) ? (srtt_ff - rtt) : (rtt - srtt_ff);
      var_sum  = {1'b0, rttvar_ff, 1'b0} + {2'b00, rttvar_ff} + {2'b00, diff};
      srtt_sum = {srtt_ff, 3'b000} - {3'b000, srtt_ff} + {3'b000, rtt};
      if (measured_ff) begin
         srtt_smp = srtt_sum[34:3];
         var_smp  = var_sum[33:2];
      end else begin
         srtt_smp = rtt;
         var_smp  = {1'b0, rtt[31:1]};
      end
      var_term  = {var_smp, 2'b00};
      var_floor = (var_term < {2'b00, limits.min_rto}) ? {2'b00, limits.min_rto} : var_term;
      rto_sum   = {3'b000, srtt_smp} + {1'b0, var_floor};
      rto_smp   = (rto_sum > {3'b000, limits.max_rto}) ? limits.max_rto : rto_sum[31:0];
   end

   // Backoff datapath
   always_comb begin
      rto_dbl   = {rto_ff, 1'b0};
      rto_exp   = (rto_dbl > {1'b0, limits.max_rto}) ? limits.max_rto : rto_dbl[31:0];
      retry_inc = (retry_ff < RETRY_SAT) ? retry_ff + 4'd1 : RETRY_SAT;
   end

   always_comb begin
      srtt_in     = srtt_ff;
      rttvar_in   = rttvar_ff;
      rto_in      = rto_ff;
      measured_in = measured_ff;
      min_rtt_in  = min_rtt_ff;
      retry_in    = retry_ff;
      timeout_in  = timeout_ff;
      abort_now   = 1'b0;
      if (take) begin
         unique case (item.op)
            OP_SAMPLE: begin
               srtt_in     = srtt_smp;
               rttvar_in   = var_smp;
               rto_in      = rto_smp;
               measured_in = 1'b1;
               if ((rtt != '0) && ((min_rtt_ff == '0) || (rtt < min_rtt_ff))) begin
                  min_rtt_in = rtt;
               end
            end
            OP_EXPIRE: begin
               retry_in = retry_inc;
               if (retry_inc > RetryLimit) begin
                  abort_now = 1'b1;
               end else begin
                  rto_in     = rto_exp;
                  timeout_in = timeout_ff + 32'd1;
               end
            end
            OP_ARM: begin
               retry_in = '0;
            end
            default: begin
            end
         endcase
      end else if (init_load.valid && !measured_ff) begin
         // Initial RTO write reloads the timeout until the first sample
         rto_in = init_load.value;
      end
   end

   always_comb begin
      payload_in.rto           = rto_in;
      payload_in.smoothed_rtt  = srtt_in;
      payload_in.rtt_variance  = rttvar_in;
      payload_in.lowest_rtt    = min_rtt_in;
      payload_in.retry_count   = retry_in;
      payload_in.abort_flag    = abort_now;
      payload_in.timeout_total = timeout_in;
      rsp_valid_in = take | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srtt_ff      <= '0;
         rttvar_ff    <= '0;
         rto_ff       <= INITIAL_RTO_RESET;
         measured_ff  <= 1'b0;
         min_rtt_ff   <= '0;
         retry_ff     <= '0;
         timeout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         srtt_ff      <= srtt_in;
         rttvar_ff    <= rttvar_in;
         rto_ff       <= rto_in;
         measured_ff  <= measured_in;
         min_rtt_ff   <= min_rtt_in;
         retry_ff     <= retry_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = payload_ff;

`ifndef SYNTHESIS
   a_abort_past_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && payload_ff.abort_flag) |-> (payload_ff.retry_count > RetryLimit))
      else $error("abort reported below the retry limit");

   a_backoff_clamped: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == OP_EXPIRE && !abort_now) |=> (rto_ff <= $past(limits.max_rto)))
      else $error("backed-off RTO exceeds max_rto");

   a_timeout_counted: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == OP_EXPIRE && !abort_now) |=> (timeout_ff == $past(timeout_ff) + 32'd1))
      else $error("timeout not counted on backoff");

   a_arm_clears_retry: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == OP_ARM) |=> (retry_ff == '0))
      else $error("timer arm did not clear retry count");
`endif

endmodule

/* sv/tcp_rto_estimator_backoff.sv */
// Top level of the TCP retransmission-timeout estimator with exponential backoff.
//
// Takes one event beat per cycle while req_stall is low (RTT sample, timer
// expiry or timer arm) and returns one result beat per event with the state
// after that event: RTO, smoothed RTT, RTT variation, lowest nonzero RTT,
// retry count, abort flag and total timeouts. Sustained rate is one beat per
// clock while rsp_stall is low; the limit is the state update in the back
// stage, where each event reads the state the previous one wrote. A request
// beat goes through the front register, the two-entry queue and the result
// register. A stalled result side backs up into the queue; req_stall rises
// once the front register and the queue are all holding beats.
// Registers on the APB port: 0x0 initial_rto, 0x4 min_rto, 0x8 max_rto;
// writing initial_rto also reloads the current RTO until the first sample
// has been taken. Write configuration only while no beats are in flight.
module tcp_rto_estimator_backoff
   import rtoeb_pkg::*;
#(
   parameter int MAX_RETRIES = 12
)
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   // configuration port
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   logic [31:0]    initial_rto_ff, initial_rto_in;
   logic [31:0]    min_rto_ff, min_rto_in;
   logic [31:0]    max_rto_ff, max_rto_in;
   logic           csr_write;
   logic [1:0]     csr_index;
   rto_limits_type limits;
   rto_load_type   init_load;

   logic           push_valid;
   queue_item_type push_item;
   logic           queue_full;
   logic           pop_valid;
   queue_item_type pop_item;
   logic           pop_ready;

   // Configuration registers: write on the access phase, index by word
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      initial_rto_in = initial_rto_ff;
      min_rto_in     = min_rto_ff;
      max_rto_in     = max_rto_ff;
      init_load      = '{valid: 1'b0, value: pwdata};
      if (csr_write) begin
         unique case (csr_index)
            CSR_INITIAL_RTO: begin
               initial_rto_in  = pwdata;
               init_load.valid = 1'b1;
            end
            CSR_MIN_RTO: min_rto_in = pwdata;
            CSR_MAX_RTO: max_rto_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_INITIAL_RTO: prdata = initial_rto_ff;
         CSR_MIN_RTO:     prdata = min_rto_ff;
         CSR_MAX_RTO:     prdata = max_rto_ff;
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_rto_ff <= INITIAL_RTO_RESET;
         min_rto_ff     <= MIN_RTO_RESET;
         max_rto_ff     <= MAX_RTO_RESET;
      end else begin
         initial_rto_ff <= initial_rto_in;
         min_rto_ff     <= min_rto_in;
         max_rto_ff     <= max_rto_in;
      end
   end

   assign limits.min_rto = min_rto_ff;
   assign limits.max_rto = max_rto_ff;

   // Front: accept and classify
   rtoeb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   // Decoupling queue
   rtoeb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Back: state update and result register
   rtoeb_back #(
      .MAX_RETRIES (MAX_RETRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .limits      (limits),
      .init_load   (init_load),
      .item_valid  (pop_valid),
      .item        (pop_item),
      .item_ready  (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
